// ----- hw/rtl/mrs_pkg.sv -----
// Shared types, widths and codes for the multikey row sorter.
package mrs_pkg;

  localparam int KEY_W        = 32;
  localparam int MAG_W        = 64;
  localparam int ROW_IDX_W    = 6;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_W        = 3;
  localparam int KEYS_IN      = 4;
  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_KEYS_DEF = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_KEY_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_MODE_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_MODE_1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_MODE_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_MODE_3 = 3'd4;

  // Key mode codes.
  localparam logic [CFG_W-1:0] MODE_RE_ASC   = 3'd0;
  localparam logic [CFG_W-1:0] MODE_IM_ASC   = 3'd1;
  localparam logic [CFG_W-1:0] MODE_MAG_ASC  = 3'd2;
  localparam logic [CFG_W-1:0] MODE_RE_DESC  = 3'd3;
  localparam logic [CFG_W-1:0] MODE_IM_DESC  = 3'd4;
  localparam logic [CFG_W-1:0] MODE_MAG_DESC = 3'd5;

  // Compare kinds.
  localparam logic [1:0] KIND_RE  = 2'd0;
  localparam logic [1:0] KIND_IM  = 2'd1;
  localparam logic [1:0] KIND_MAG = 2'd2;

  typedef struct packed {
    logic signed [KEY_W-1:0] key0_re;
    logic signed [KEY_W-1:0] key0_im;
    logic signed [KEY_W-1:0] key1_re;
    logic signed [KEY_W-1:0] key1_im;
    logic signed [KEY_W-1:0] key2_re;
    logic signed [KEY_W-1:0] key2_im;
    logic signed [KEY_W-1:0] key3_re;
    logic signed [KEY_W-1:0] key3_im;
    logic                    last_row;
  } row_t;

  typedef struct packed {
    logic [ROW_IDX_W-1:0] row_index;
    logic                 last_out;
  } perm_t;

  typedef struct packed {
    logic feed;
    logic first;
  } mag_ctl_t;

endpackage

// ----- hw/rtl/multikey_row_sorter.sv -----
// Top level: stores rows, places each by stable insertion and emits the permutation.
// A row first stores each of its MAX_KEYS keys and squares their magnitudes, then visits
// the held rows in order, comparing keys (a magnitude key on the shared multiplier), then
// shifts order entries up to make room and is inserted. After the last row each index is
// emitted and held while the output is stalled. No row is taken meanwhile. Reset is
// synchronous: batch empty, key_count 1, all modes 0; stores not cleared.
module multikey_row_sorter #(
  parameter int MAX_ROWS = mrs_pkg::MAX_ROWS_DEF,
  parameter int MAX_KEYS = mrs_pkg::MAX_KEYS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           row_valid,
  output logic                           row_stall,
  input  mrs_pkg::row_t                  row_data,
  output logic                           perm_valid,
  input  logic                           perm_stall,
  output mrs_pkg::perm_t                 perm_data,
  input  logic                           cfg_write,
  input  logic [mrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mrs_pkg::CFG_W-1:0]      cfg_data
);
  import mrs_pkg::*;

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int RWP   = $clog2(MAX_ROWS + 1);
  localparam int KDEP  = MAX_ROWS * MAX_KEYS;
  localparam int KAW   = $clog2(KDEP);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PREP   = 3'd1;
  localparam logic [2:0] S_ORD    = 3'd2;
  localparam logic [2:0] S_KEY    = 3'd3;
  localparam logic [2:0] S_SHIFT  = 3'd4;
  localparam logic [2:0] S_INSERT = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  logic [2:0]       state;
  logic [2:0]       ph;
  logic [RWP-1:0]   rows;
  logic [RWP-1:0]   i;
  logic [RWP-1:0]   idx;
  logic [RWP-1:0]   e;
  logic [RWP-1:0]   pos;
  logic [RW-1:0]    cand;
  logic [2:0]       k;
  logic             last_r;
  logic signed [KEY_W-1:0] nk_re [KEYS_IN];
  logic signed [KEY_W-1:0] nk_im [KEYS_IN];
  logic [MAG_W-1:0] nmag [KEYS_IN];
  logic [CFG_W-1:0] kc;
  logic [CFG_W-1:0] km [KEYS_IN];

  logic             accept;
  logic [2:0]       n_eff;
  logic [1:0]       kind;
  logic             desc;
  logic             lt;
  logic             gt;
  logic             ahead;
  logic             after;
  logic [RWP-1:0]   i_inc;
  logic [RWP-1:0]   e_inc;
  logic [2:0]       k_inc;
  logic signed [KEY_W-1:0] ore;
  logic signed [KEY_W-1:0] oim;

  logic                     kr_we;
  logic [KAW-1:0]           kr_waddr;
  logic [KAW-1:0]           kr_raddr;
  logic [2*KEY_W-1:0]       kr_rdata;
  logic                     or_we;
  logic [RW-1:0]            or_waddr;
  logic [RW-1:0]            or_wdata;
  logic [RW-1:0]            or_raddr;
  logic [RW-1:0]            or_rdata;
  mag_ctl_t                 mag_ctl;
  logic signed [KEY_W-1:0]  mag_x;
  logic [MAG_W-1:0]         mag_acc;

  assign row_stall = (state != S_IDLE);
  assign accept    = row_valid && !row_stall;
  assign i_inc     = i + RWP'(1);
  assign e_inc     = e + RWP'(1);
  assign k_inc     = k + 3'd1;
  assign ore       = kr_rdata[2*KEY_W-1:KEY_W];
  assign oim       = kr_rdata[KEY_W-1:0];

  // Number of keys in use, with zero and oversize counts clamped.
  always_comb begin
    if (kc == 3'd0) begin
      n_eff = 3'd1;
    end else if (kc > 3'(MAX_KEYS)) begin
      n_eff = 3'(MAX_KEYS);
    end else begin
      n_eff = kc;
    end
  end

  // Decode the mode of the current key.
  always_comb begin
    case (km[k[1:0]])
      MODE_RE_ASC:   begin kind = KIND_RE;  desc = 1'b0; end
      MODE_IM_ASC:   begin kind = KIND_IM;  desc = 1'b0; end
      MODE_MAG_ASC:  begin kind = KIND_MAG; desc = 1'b0; end
      MODE_RE_DESC:  begin kind = KIND_RE;  desc = 1'b1; end
      MODE_IM_DESC:  begin kind = KIND_IM;  desc = 1'b1; end
      MODE_MAG_DESC: begin kind = KIND_MAG; desc = 1'b1; end
      default:       begin kind = KIND_RE;  desc = 1'b0; end
    endcase
  end

  // Compare the new row against the candidate on the current key.
  always_comb begin
    case (kind)
      KIND_IM: begin
        lt = nk_im[k[1:0]] < oim;
        gt = nk_im[k[1:0]] > oim;
      end
      KIND_MAG: begin
        lt = nmag[k[1:0]] < mag_acc;
        gt = nmag[k[1:0]] > mag_acc;
      end
      default: begin
        lt = nk_re[k[1:0]] < ore;
        gt = nk_re[k[1:0]] > ore;
      end
    endcase
    ahead = desc ? gt : lt;
    after = desc ? lt : gt;
  end

  // Memory and multiplier controls.
  always_comb begin
    kr_we       = (state == S_PREP) && (ph == 3'd0);
    kr_waddr    = KAW'(KAW'(rows[RW-1:0]) * KAW'(MAX_KEYS) + KAW'(k));
    kr_raddr    = KAW'(KAW'(cand) * KAW'(MAX_KEYS) + KAW'(k));
    or_we       = 1'b0;
    or_waddr    = idx[RW-1:0];
    or_wdata    = or_rdata;
    or_raddr    = i[RW-1:0];
    mag_ctl     = '0;
    mag_x       = nk_re[k[1:0]];
    case (state)
      S_PREP: begin
        mag_ctl.feed  = (ph == 3'd0) || (ph == 3'd1);
        mag_ctl.first = (ph == 3'd0);
        mag_x         = (ph == 3'd0) ? nk_re[k[1:0]] : nk_im[k[1:0]];
      end
      S_KEY: begin
        mag_ctl.feed  = (kind == KIND_MAG) && ((ph == 3'd1) || (ph == 3'd2));
        mag_ctl.first = (ph == 3'd1);
        mag_x         = (ph == 3'd1) ? ore : oim;
      end
      S_SHIFT: begin
        or_raddr = RW'(idx - RWP'(1));
        or_we    = (ph == 3'd1);
      end
      S_INSERT: begin
        or_we    = 1'b1;
        or_waddr = pos[RW-1:0];
        or_wdata = rows[RW-1:0];
      end
      S_EMIT: begin
        or_raddr = e[RW-1:0];
      end
      default: begin
        or_we = 1'b0;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      kc <= 3'd1;
      for (int j = 0; j < KEYS_IN; j++) begin
        km[j] <= MODE_RE_ASC;
      end
    end else if (cfg_write) begin
      case (cfg_index)
        REG_KEY_COUNT:  kc    <= cfg_data;
        REG_KEY_MODE_0: km[0] <= cfg_data;
        REG_KEY_MODE_1: km[1] <= cfg_data;
        REG_KEY_MODE_2: km[2] <= cfg_data;
        REG_KEY_MODE_3: km[3] <= cfg_data;
        default:        kc    <= kc;
      endcase
    end
  end

  // Latch the incoming row keys.
  always_ff @(posedge clk) begin
    if (accept) begin
      nk_re[0] <= row_data.key0_re;
      nk_im[0] <= row_data.key0_im;
      nk_re[1] <= row_data.key1_re;
      nk_im[1] <= row_data.key1_im;
      nk_re[2] <= row_data.key2_re;
      nk_im[2] <= row_data.key2_im;
      nk_re[3] <= row_data.key3_re;
      nk_im[3] <= row_data.key3_im;
    end
    if ((state == S_PREP) && (ph == 3'd3)) begin
      nmag[k[1:0]] <= mag_acc;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ph         <= 3'd0;
      rows       <= '0;
      perm_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            last_r <= row_data.last_row;
            ph     <= 3'd0;
            k      <= 3'd0;
            e      <= '0;
            if (rows < RWP'(MAX_ROWS)) begin
              state <= S_PREP;
            end else if (row_data.last_row) begin
              state <= S_EMIT;
            end
          end
        end
        S_PREP: begin
          if (ph == 3'd3) begin
            ph <= 3'd0;
            if (k == 3'(MAX_KEYS - 1)) begin
              k <= 3'd0;
              i <= '0;
              if (rows == '0) begin
                pos   <= '0;
                state <= S_INSERT;
              end else begin
                state <= S_ORD;
              end
            end else begin
              k <= k_inc;
            end
          end else begin
            ph <= ph + 3'd1;
          end
        end
        S_ORD: begin
          if (ph == 3'd0) begin
            ph <= 3'd1;
          end else begin
            cand  <= or_rdata;
            k     <= 3'd0;
            ph    <= 3'd0;
            state <= S_KEY;
          end
        end
        S_KEY: begin
          if ((ph == 3'd0) || ((kind == KIND_MAG) && (ph != 3'd4))) begin
            ph <= ph + 3'd1;
          end else begin
            ph <= 3'd0;
            if (ahead) begin
              pos   <= i;
              idx   <= rows;
              state <= S_SHIFT;
            end else if (after || (k_inc == n_eff)) begin
              if (i_inc == rows) begin
                pos   <= rows;
                state <= S_INSERT;
              end else begin
                i     <= i_inc;
                state <= S_ORD;
              end
            end else begin
              k <= k_inc;
            end
          end
        end
        S_SHIFT: begin
          if (ph == 3'd0) begin
            if (idx == pos) begin
              state <= S_INSERT;
            end else begin
              ph <= 3'd1;
            end
          end else begin
            idx <= idx - RWP'(1);
            ph  <= 3'd0;
          end
        end
        S_INSERT: begin
          rows  <= rows + RWP'(1);
          ph    <= 3'd0;
          e     <= '0;
          state <= last_r ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          case (ph)
            3'd0: ph <= 3'd1;
            3'd1: begin
              perm_data.row_index <= ROW_IDX_W'(or_rdata);
              perm_data.last_out  <= (e_inc == rows);
              perm_valid          <= 1'b1;
              ph                  <= 3'd2;
            end
            default: begin
              if (perm_valid && !perm_stall) begin
                perm_valid <= 1'b0;
                ph         <= 3'd0;
                if (e_inc == rows) begin
                  rows  <= '0;
                  state <= S_IDLE;
                end else begin
                  e <= e_inc;
                end
              end
            end
          endcase
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  mrs_ram #(.WIDTH(2*KEY_W), .DEPTH(KDEP)) u_key_ram (
    .clk   (clk),
    .we    (kr_we),
    .waddr (kr_waddr),
    .wdata ({nk_re[k[1:0]], nk_im[k[1:0]]}),
    .raddr (kr_raddr),
    .rdata (kr_rdata)
  );

  mrs_ram #(.WIDTH(RW), .DEPTH(MAX_ROWS)) u_order_ram (
    .clk   (clk),
    .we    (or_we),
    .waddr (or_waddr),
    .wdata (or_wdata),
    .raddr (or_raddr),
    .rdata (or_rdata)
  );

  mrs_mag u_mag (
    .clk (clk),
    .rst (rst),
    .ctl (mag_ctl),
    .x   (mag_x),
    .acc (mag_acc)
  );

endmodule

// ----- hw/rtl/mrs_ram.sv -----
// Simple dual-port memory with one write port and a registered read port.
module mrs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/mrs_mag.sv -----
// Shared squaring multiplier with accumulator for squared magnitudes.
module mrs_mag (
  input  logic                          clk,
  input  logic                          rst,
  input  mrs_pkg::mag_ctl_t             ctl,
  input  logic signed [mrs_pkg::KEY_W-1:0] x,
  output logic [mrs_pkg::MAG_W-1:0]     acc
);
  import mrs_pkg::*;

  logic [KEY_W-1:0] ax;
  logic [MAG_W-1:0] prod;
  logic             p_feed;
  logic             p_first;

  // The magnitude of the most negative value still fits unsigned.
  assign ax = x[KEY_W-1] ? KEY_W'(-x) : KEY_W'(x);

  // Multiply stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      p_feed  <= 1'b0;
      p_first <= 1'b0;
    end else begin
      p_feed  <= ctl.feed;
      p_first <= ctl.first;
    end
    prod <= MAG_W'(ax) * MAG_W'(ax);
  end

  // Accumulate stage.
  always_ff @(posedge clk) begin
    if (p_feed) begin
      acc <= p_first ? prod : acc + prod;
    end
  end

endmodule

// ----- hw/rtl/mrs_checker.sv -----
// Port-level checker for the multikey row sorter and its bind.
module mrs_checker (
  input logic           clk,
  input logic           rst,
  input logic           row_valid,
  input logic           row_stall,
  input mrs_pkg::row_t  row_data,
  input logic           perm_valid,
  input logic           perm_stall,
  input mrs_pkg::perm_t perm_data
);

  // A stalled request keeps its payload.
  a_perm_hold: assert property (@(posedge clk) disable iff (rst)
    perm_valid && perm_stall |=> perm_valid && $stable(perm_data))
    else $error("stalled permutation request changed");

  // No row is taken while indexes are being emitted.
  a_no_row_in_emit: assert property (@(posedge clk) disable iff (rst)
    perm_valid |-> row_stall)
    else $error("row accepted during emission");

  // The final index ends the emission.
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    perm_valid && !perm_stall && perm_data.last_out |=> !perm_valid)
    else $error("request after the final index");

  // A last row always starts work before the next row.
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    row_valid && !row_stall && row_data.last_row |=> row_stall)
    else $error("ready right after a last row");

endmodule

bind multikey_row_sorter mrs_checker u_mrs_checker (.*);
